/* rtl/fsc_pkg.sv */
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types, constants and helpers of the focuser serial command engine.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int CMD_LEN            = 8;
  localparam int POS_W              = 20;
  localparam int ARG_W              = 17;
  localparam int TEMP_W             = 12;
  localparam logic [19:0] MAX_TRAVEL_DEFAULT = 20'd65535;
  localparam logic [19:0] NUM_SAT   = 20'd999999;

  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_1 = 8'h31;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] CH_9 = 8'h39;

  localparam logic [7:0] CMD_GOTO  = 8'h47;
  localparam logic [7:0] CMD_SET   = 8'h53;
  localparam logic [7:0] CMD_IN    = 8'h49;
  localparam logic [7:0] CMD_OUT   = 8'h4F;
  localparam logic [7:0] CMD_MAXT  = 8'h4C;
  localparam logic [7:0] CMD_POWER = 8'h50;
  localparam logic [7:0] CMD_BACK  = 8'h42;
  localparam logic [7:0] CMD_CONF  = 8'h43;
  localparam logic [7:0] CMD_TEMP  = 8'h54;
  localparam logic [7:0] CMD_VER   = 8'h56;

  localparam logic [63:0] REPLY_VER  = "FV000300";
  localparam logic [63:0] REPLY_BACK = "FB200000";
  localparam logic [63:0] REPLY_CONF = "FC000DEF";
  localparam logic [63:0] REPLY_PWR  = "FP000000";

  localparam logic [19:0] RECIP10 = 20'd838861;
  localparam logic [15:0] RECIP5  = 16'd52429;
  localparam logic [15:0] RECIP10S = 16'd6554;
  localparam logic [17:0] RECIP70 = 18'd239675;
  localparam logic [12:0] KELVIN_OFS = 13'd2738;

  typedef struct packed {
    logic               evt;
    logic [63:0]        chars;
    logic [POS_W-1:0]   pos;
    logic signed [TEMP_W-1:0] temp;
  } job_t;

  typedef struct packed {
    logic [7:0]       resp_byte;
    logic             byte_valid;
    logic             last;
    logic             move_start;
    logic [POS_W-1:0] move_target;
    logic             set_position;
    logic [ARG_W-1:0] new_position;
    logic             abort_move;
    logic             save_max_travel;
  } res_t;

  typedef enum logic [2:0] {
    B_IDLE, B_ARG, B_EXEC, B_TEMP0, B_TEMP1, B_TEMP2, B_CONV, B_EMIT
  } bstate_t;

  function automatic logic [7:0] upcase(input logic [7:0] b);
    upcase = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
  endfunction

  function automatic logic [19:0] sat_num(input logic [19:0] v);
    sat_num = (v > NUM_SAT) ? NUM_SAT : v;
  endfunction

endpackage

/* rtl/fsc_front.sv */
// ----------------------------------------------------------------------------
// fsc_front
// Accepts input words, assembles command frames and queues jobs.
// ----------------------------------------------------------------------------
module fsc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic [7:0]                 in_byte,
  input  logic [fsc_pkg::POS_W-1:0]  in_pos,
  input  logic signed [fsc_pkg::TEMP_W-1:0] in_temp,
  input  logic                       q_full,
  output logic                       push,
  output fsc_pkg::job_t              job
);

  logic        active_r, active_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] chars_r;
  logic        wr_en;
  logic [2:0]  wr_idx;
  logic        acc;

  always_comb begin
    in_ready   = !q_full;
    acc        = in_valid && in_ready;
    push       = 1'b0;
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    wr_en      = 1'b0;
    wr_idx     = cnt_r[2:0];
    job.evt    = in_func;
    job.chars  = chars_r;
    job.pos    = in_pos;
    job.temp   = in_temp;
    if (acc) begin
      if (in_func) begin
        push = 1'b1;
      end else if (!active_r) begin
        if (fsc_pkg::upcase(in_byte) == fsc_pkg::CH_F) begin
          active_nxt = 1'b1;
          cnt_nxt    = 4'd1;
          wr_en      = 1'b1;
          wr_idx     = 3'd0;
        end
      end else if (cnt_r == 4'(fsc_pkg::CMD_LEN)) begin
        push       = 1'b1;
        active_nxt = 1'b0;
        cnt_nxt    = 4'd0;
      end else begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= 4'd0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) chars_r[8*wr_idx +: 8] <= fsc_pkg::upcase(in_byte);
  end

endmodule

/* rtl/fsc_queue.sv */
// ----------------------------------------------------------------------------
// fsc_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module fsc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fsc_pkg::job_t wr_job,
  input  logic          pop,
  output fsc_pkg::job_t rd_job,
  output logic          full,
  output logic          empty
);

  fsc_pkg::job_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_job;
  end

endmodule

/* rtl/fsc_back.sv */
// ----------------------------------------------------------------------------
// fsc_back
// Executes queued jobs: parses the argument, runs the command, formats and
// streams the reply words with their checksum.
// ----------------------------------------------------------------------------
module fsc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          exp_mode,
  input  logic          q_empty,
  input  fsc_pkg::job_t q_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output fsc_pkg::res_t res
);

  fsc_pkg::bstate_t state_r, state_nxt;
  fsc_pkg::job_t    job_r, job_nxt;
  logic [16:0]      arg_r, arg_nxt;
  logic [2:0]       aidx_r, aidx_nxt;
  logic             stop_r, stop_nxt;
  logic [7:0]       txt_r [8];
  logic [7:0]       txt_nxt [8];
  logic [19:0]      conv_r, conv_nxt;
  logic [2:0]       didx_r, didx_nxt;
  logic [3:0]       oidx_r, oidx_nxt;
  logic             single_r, single_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             mv_r, mv_nxt, setp_r, setp_nxt, abrt_r, abrt_nxt, save_r, save_nxt;
  logic [19:0]      tgt_r, tgt_nxt;
  logic [16:0]      newp_r, newp_nxt;
  logic [19:0]      maxt_r, maxt_nxt;
  logic [3:0]       pwr_r, pwr_nxt;
  logic signed [18:0] tw_r, tw_nxt;

  logic [7:0]  ch, cmd;
  logic [19:0] arg20, clamp_g, q20, q10, rem;
  logic [20:0] sum_o;
  logic [39:0] prod10;
  logic [28:0] prod5;
  logic [27:0] prods;
  logic [35:0] prod70;
  logic [12:0] kx;
  logic [11:0] tabs;
  logic [8:0]  dq;
  logic [7:0]  cur_byte;

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    arg_nxt    = arg_r;
    aidx_nxt   = aidx_r;
    stop_nxt   = stop_r;
    txt_nxt    = txt_r;
    conv_nxt   = conv_r;
    didx_nxt   = didx_r;
    oidx_nxt   = oidx_r;
    single_nxt = single_r;
    sum_nxt    = sum_r;
    mv_nxt     = mv_r;
    tgt_nxt    = tgt_r;
    setp_nxt   = setp_r;
    newp_nxt   = newp_r;
    abrt_nxt   = abrt_r;
    save_nxt   = save_r;
    maxt_nxt   = maxt_r;
    pwr_nxt    = pwr_r;
    tw_nxt     = tw_r;
    pop        = 1'b0;

    ch      = job_r.chars[8*aidx_r +: 8];
    cmd     = job_r.chars[15:8];
    arg20   = {3'b0, arg_r};
    clamp_g = (arg20 > maxt_r) ? maxt_r : arg20;
    sum_o   = {1'b0, job_r.pos} + {4'b0, arg_r};
    prod10  = conv_r * fsc_pkg::RECIP10;
    q20     = {3'b0, prod10[39:23]};
    q10     = (q20 << 3) + (q20 << 1);
    rem     = conv_r - q10;
    kx      = 13'(job_r.temp) + fsc_pkg::KELVIN_OFS;
    prod5   = kx * fsc_pkg::RECIP5;
    tabs    = job_r.temp[11] ? 12'(-job_r.temp) : 12'(job_r.temp);
    prods   = tabs * fsc_pkg::RECIP10S;
    dq      = {1'b0, prods[23:16]};
    prod70  = tw_r[17:0] * fsc_pkg::RECIP70;

    cur_byte = single_r ? 8'd0 : ((oidx_r == 4'd8) ? sum_r : txt_r[oidx_r[2:0]]);
    out_valid = (state_r == fsc_pkg::B_EMIT);
    res.resp_byte       = cur_byte;
    res.byte_valid      = !single_r;
    res.last            = single_r || (oidx_r == 4'd8);
    res.move_start      = mv_r;
    res.move_target     = tgt_r;
    res.set_position    = setp_r;
    res.new_position    = newp_r;
    res.abort_move      = abrt_r;
    res.save_max_travel = save_r;

    unique case (state_r)
      fsc_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          job_nxt    = q_job;
          arg_nxt    = 17'd0;
          aidx_nxt   = 3'd3;
          stop_nxt   = 1'b0;
          oidx_nxt   = 4'd0;
          sum_nxt    = 8'd0;
          single_nxt = 1'b0;
          mv_nxt     = 1'b0;
          tgt_nxt    = 20'd0;
          setp_nxt   = 1'b0;
          newp_nxt   = 17'd0;
          abrt_nxt   = 1'b0;
          save_nxt   = 1'b0;
          didx_nxt   = 3'd7;
          txt_nxt[0] = fsc_pkg::CH_F;
          txt_nxt[1] = fsc_pkg::CH_D;
          conv_nxt   = fsc_pkg::sat_num(q_job.pos);
          state_nxt  = q_job.evt ? fsc_pkg::B_CONV : fsc_pkg::B_ARG;
        end
      end
      fsc_pkg::B_ARG: begin
        if (!stop_r && ch >= fsc_pkg::CH_0 && ch <= fsc_pkg::CH_9) begin
          arg_nxt = (arg_r << 3) + (arg_r << 1) + {13'd0, ch[3:0]};
        end else begin
          stop_nxt = 1'b1;
        end
        aidx_nxt = aidx_r + 3'd1;
        if (aidx_r == 3'd7) state_nxt = fsc_pkg::B_EXEC;
      end
      fsc_pkg::B_EXEC: begin
        unique case (cmd)
          fsc_pkg::CMD_GOTO: begin
            if (clamp_g != 20'd0) begin
              mv_nxt     = 1'b1;
              tgt_nxt    = clamp_g;
              single_nxt = 1'b1;
              state_nxt  = fsc_pkg::B_EMIT;
            end else begin
              state_nxt = fsc_pkg::B_CONV;
            end
          end
          fsc_pkg::CMD_SET: begin
            if (arg_r != 17'd0) begin
              setp_nxt = 1'b1;
              newp_nxt = arg_r;
              conv_nxt = arg20;
            end
            state_nxt = fsc_pkg::B_CONV;
          end
          fsc_pkg::CMD_IN: begin
            mv_nxt     = 1'b1;
            tgt_nxt    = (arg20 > job_r.pos) ? 20'd1 : job_r.pos - arg20;
            single_nxt = 1'b1;
            state_nxt  = fsc_pkg::B_EMIT;
          end
          fsc_pkg::CMD_OUT: begin
            mv_nxt     = 1'b1;
            tgt_nxt    = (sum_o > {1'b0, maxt_r}) ? maxt_r : sum_o[19:0];
            single_nxt = 1'b1;
            state_nxt  = fsc_pkg::B_EMIT;
          end
          fsc_pkg::CMD_MAXT: begin
            if (arg_r != 17'd0) begin
              maxt_nxt = arg20;
              save_nxt = 1'b1;
              for (int i = 0; i < 8; i++) txt_nxt[i] = job_r.chars[8*i +: 8];
              state_nxt = fsc_pkg::B_EMIT;
            end else begin
              txt_nxt[1] = fsc_pkg::CH_L;
              conv_nxt   = fsc_pkg::sat_num(maxt_r);
              state_nxt  = fsc_pkg::B_CONV;
            end
          end
          fsc_pkg::CMD_POWER: begin
            for (int i = 0; i < 8; i++) txt_nxt[i] = fsc_pkg::REPLY_PWR[63-8*i -: 8];
            for (int i = 0; i < 4; i++) begin
              if (job_r.chars[8*(4+i) +: 8] == fsc_pkg::CH_1) pwr_nxt[i] = 1'b0;
              if (job_r.chars[8*(4+i) +: 8] == fsc_pkg::CH_2) pwr_nxt[i] = 1'b1;
              txt_nxt[4+i] = pwr_nxt[i] ? fsc_pkg::CH_2 : fsc_pkg::CH_1;
            end
            state_nxt = fsc_pkg::B_EMIT;
          end
          fsc_pkg::CMD_BACK: begin
            for (int i = 0; i < 8; i++) txt_nxt[i] = fsc_pkg::REPLY_BACK[63-8*i -: 8];
            state_nxt = fsc_pkg::B_EMIT;
          end
          fsc_pkg::CMD_CONF: begin
            for (int i = 0; i < 8; i++) txt_nxt[i] = fsc_pkg::REPLY_CONF[63-8*i -: 8];
            state_nxt = fsc_pkg::B_EMIT;
          end
          fsc_pkg::CMD_TEMP: begin
            txt_nxt[1] = fsc_pkg::CH_T;
            state_nxt  = fsc_pkg::B_TEMP0;
          end
          fsc_pkg::CMD_VER: begin
            abrt_nxt = 1'b1;
            for (int i = 0; i < 8; i++) txt_nxt[i] = fsc_pkg::REPLY_VER[63-8*i -: 8];
            state_nxt = fsc_pkg::B_EMIT;
          end
          default: state_nxt = fsc_pkg::B_IDLE;
        endcase
      end
      fsc_pkg::B_TEMP0: begin
        if (exp_mode) begin
          tw_nxt    = (job_r.temp[11] ? -19'($signed({1'b0, dq})) : 19'($signed({1'b0, dq})))
                      + 19'sd20;
          state_nxt = fsc_pkg::B_TEMP1;
        end else begin
          conv_nxt  = {9'd0, prod5[28:18]};
          state_nxt = fsc_pkg::B_CONV;
        end
      end
      fsc_pkg::B_TEMP1: begin
        tw_nxt    = (tw_r <<< 10) - tw_r;
        state_nxt = fsc_pkg::B_TEMP2;
      end
      fsc_pkg::B_TEMP2: begin
        conv_nxt  = tw_r[18] ? 20'd0 : {8'd0, prod70[35:24]};
        state_nxt = fsc_pkg::B_CONV;
      end
      fsc_pkg::B_CONV: begin
        txt_nxt[didx_r] = fsc_pkg::CH_0 + {4'd0, rem[3:0]};
        conv_nxt        = q20;
        didx_nxt        = didx_r - 3'd1;
        if (didx_r == 3'd2) state_nxt = fsc_pkg::B_EMIT;
      end
      fsc_pkg::B_EMIT: begin
        if (out_ready) begin
          sum_nxt  = sum_r + cur_byte;
          mv_nxt   = 1'b0;
          tgt_nxt  = 20'd0;
          setp_nxt = 1'b0;
          newp_nxt = 17'd0;
          abrt_nxt = 1'b0;
          save_nxt = 1'b0;
          oidx_nxt = oidx_r + 4'd1;
          if (res.last) state_nxt = fsc_pkg::B_IDLE;
        end
      end
      default: state_nxt = fsc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsc_pkg::B_IDLE;
      maxt_r  <= fsc_pkg::MAX_TRAVEL_DEFAULT;
      pwr_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      maxt_r  <= maxt_nxt;
      pwr_r   <= pwr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    arg_r    <= arg_nxt;
    aidx_r   <= aidx_nxt;
    stop_r   <= stop_nxt;
    txt_r    <= txt_nxt;
    conv_r   <= conv_nxt;
    didx_r   <= didx_nxt;
    oidx_r   <= oidx_nxt;
    single_r <= single_nxt;
    sum_r    <= sum_nxt;
    mv_r     <= mv_nxt;
    tgt_r    <= tgt_nxt;
    setp_r   <= setp_nxt;
    newp_r   <= newp_nxt;
    abrt_r   <= abrt_nxt;
    save_r   <= save_nxt;
    tw_r     <= tw_nxt;
  end

endmodule

/* rtl/focuser_serial_command_engine_unit.sv */
// ----------------------------------------------------------------------------
// focuser_serial_command_engine_unit
// Focuser serial command engine: frames serial words into commands, runs them
// and streams replies with an additive checksum.
// ----------------------------------------------------------------------------
// Flow: for a frame end the back sequencer scans the argument and runs the
// command; a done event skips both. Up to 3 temperature steps and 6
// digit-conversion steps follow where the reply needs them, then the reply
// words stream out; a new job is taken only after the last reply word.
// Other words are accepted while the two-entry job queue has room.
// Reset: synchronous, active low; clears framing, queue, power switches and
// restores the default maximum travel.
// ----------------------------------------------------------------------------
module focuser_serial_command_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // rx_byte[7:0], motor_position[27:8], temperature_tenths[39:28]
  input  logic        in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata, // resp_byte[7:0], move_start[8], move_target[28:9],
                                 // set_position[29], new_position[46:30], abort_move[47],
                                 // save_max_travel[48], zero[55:49]
  output logic        out_tuser, // byte_valid
  output logic        out_tlast, // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic          exp_mode_r;
  logic          q_full, q_empty, push, pop;
  fsc_pkg::job_t wr_job, rd_job;
  fsc_pkg::res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) exp_mode_r <= 1'b0;
    else if (cfg_valid && cfg_ready) exp_mode_r <= cfg_data;
  end

  fsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_func  (in_tuser),
    .in_byte  (in_tdata[7:0]),
    .in_pos   (in_tdata[27:8]),
    .in_temp  ($signed(in_tdata[39:28])),
    .q_full   (q_full),
    .push     (push),
    .job      (wr_job)
  );

  fsc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  fsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .exp_mode  (exp_mode_r),
    .q_empty   (q_empty),
    .q_job     (rd_job),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {7'd0, res.save_max_travel, res.abort_move, res.new_position,
                      res.set_position, res.move_target, res.move_start, res.resp_byte};
  assign out_tuser = res.byte_valid;
  assign out_tlast = res.last;

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("strobe-only word not marked last");

  a_single_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (out_tdata[8] || out_tdata[29] || out_tdata[47] || out_tdata[48]))
    else $error("strobe-only word without strobe");

  a_strobe_first_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      !out_tdata[8] && !out_tdata[29] && !out_tdata[47] && !out_tdata[48])
    else $error("strobe on later reply word");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("job taken from empty queue");

endmodule
